>>> hw/rtl/cdmts_pkg.sv
package cdmts_pkg;

  // Display modes
  typedef enum logic [1:0] {
    MODE_TEMP  = 2'd0,
    MODE_CLOCK = 2'd1,
    MODE_SETUP = 2'd2
  } mode_t;

  // Event kinds
  typedef enum logic [1:0] {
    OP_TIME = 2'd0,
    OP_TEMP = 2'd1,
    OP_KEY  = 2'd2
  } opcode_t;

  // Key codes
  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_MODE = 3'd1,
    KEY_UP   = 3'd2,
    KEY_DOWN = 3'd3,
    KEY_OK   = 3'd4
  } key_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CLOCK_DWELL    = 2'd0,
    CFG_TEMP_DWELL     = 2'd1,
    CFG_CONVERT_PERIOD = 2'd2
  } cfg_idx_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  // Digit codes beyond the numerals
  localparam logic [3:0] DIG_C     = 4'd10;
  localparam logic [3:0] DIG_BLANK = 4'd11;

  // Reset values of the configuration registers
  localparam logic [5:0] CLOCK_DWELL_RST    = 6'd20;
  localparam logic [3:0] TEMP_DWELL_RST     = 4'd4;
  localparam logic [3:0] CONVERT_PERIOD_RST = 4'd4;

  // Wrap limits of the hour and minute fields
  localparam logic [7:0] HOUR_LIMIT   = 8'd24;
  localparam logic [7:0] MINUTE_LIMIT = 8'd60;

  // Reciprocal of ten, exact for 0..1028 with a shift of 11
  localparam logic [15:0] DIV10_MUL   = 16'd205;
  localparam int          DIV10_SHIFT = 11;

  typedef struct packed {
    logic [5:0] clock_dwell;
    logic [3:0] temp_dwell;
    logic [3:0] convert_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         hour_bcd;
    logic [6:0]         minute_bcd;
    logic signed [15:0] temp_raw;
    logic [2:0]         key;
  } in_t;

  typedef struct packed {
    logic [3:0] digit_hi0;
    logic [3:0] digit_hi1;
    logic [3:0] digit_lo0;
    logic [3:0] digit_lo1;
    logic       point_flash;
    logic [1:0] mode;
    logic       edit_minutes;
    logic       time_write;
    logic [5:0] write_hour_bcd;
    logic [6:0] write_minute_bcd;
    logic       convert_request;
  } res_t;

  typedef struct packed {
    logic [4:0] quo;
    logic [3:0] rem;
  } div10_t;

  // Quotient and remainder of an 8-bit value by ten
  function automatic div10_t div10(input logic [7:0] x);
    logic [15:0] prod;
    div10_t      d;
    prod  = 16'(x) * DIV10_MUL;
    d.quo = prod[15:DIV10_SHIFT];
    d.rem = 4'(x - 8'(d.quo) * 8'd10);
    return d;
  endfunction

  // Remainder by ten of a value below thirty
  function automatic logic [3:0] mod10_small(input logic [4:0] q);
    logic [4:0] r;
    if (q >= 5'd20) begin
      r = q - 5'd20;
    end else if (q >= 5'd10) begin
      r = q - 5'd10;
    end else begin
      r = q;
    end
    return 4'(r);
  endfunction

endpackage

>>> hw/rtl/cdmts_cfg_regs.sv
module cdmts_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cdmts_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cdmts_pkg::CfgDataW-1:0] cfg_data,
  output cdmts_pkg::cfg_t                cfg
);
  import cdmts_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_dwell    <= CLOCK_DWELL_RST;
      cfg_r.temp_dwell     <= TEMP_DWELL_RST;
      cfg_r.convert_period <= CONVERT_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLOCK_DWELL:    cfg_r.clock_dwell    <= cfg_data;
        CFG_TEMP_DWELL:     cfg_r.temp_dwell     <= cfg_data[3:0];
        CFG_CONVERT_PERIOD: cfg_r.convert_period <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/cdmts_core.sv
module cdmts_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  cdmts_pkg::in_t  item,
  input  cdmts_pkg::cfg_t cfg,
  output cdmts_pkg::res_t res
);
  import cdmts_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [3:0] dig_r [4];
  logic [3:0] dig_nxt [4];
  logic       point_r, point_nxt;
  logic       edit_r, edit_nxt;
  logic [5:0] ccnt_r, ccnt_nxt;
  logic [3:0] tcnt_r, tcnt_nxt;
  logic [3:0] vcnt_r, vcnt_nxt;
  logic       wr, conv;

  // Counter increments and dwell checks
  logic [5:0] ccnt_inc;
  logic [3:0] tcnt_inc, vcnt_inc;
  logic       clock_hit, temp_hit, conv_hit;

  assign ccnt_inc  = ccnt_r + 6'd1;
  assign tcnt_inc  = tcnt_r + 4'd1;
  assign vcnt_inc  = vcnt_r + 4'd1;
  assign clock_hit = ccnt_inc >= cfg.clock_dwell;
  assign temp_hit  = tcnt_inc >= cfg.temp_dwell;
  assign conv_hit  = vcnt_inc >= cfg.convert_period;

  // Whole degrees: bits 11..4 as an unsigned byte
  logic [7:0] deg;
  div10_t     deg_d;

  assign deg   = item.temp_raw[11:4];
  assign deg_d = div10(deg);

  // Field step for up/down: nibbles above 9 enter the sum as they are
  logic [3:0] fld_hi, fld_lo;
  logic [7:0] fld_val, fld_lim, fld_new;
  div10_t     fld_d;

  assign fld_hi  = edit_r ? dig_r[2] : dig_r[0];
  assign fld_lo  = edit_r ? dig_r[3] : dig_r[1];
  assign fld_lim = edit_r ? MINUTE_LIMIT : HOUR_LIMIT;
  assign fld_val = {1'b0, fld_hi, 3'b000} + {3'b000, fld_hi, 1'b0} + {4'b0000, fld_lo};

  always_comb begin
    if (item.key == KEY_UP) begin
      fld_new = (fld_val + 8'd1 == fld_lim) ? 8'd0 : fld_val + 8'd1;
    end else begin
      fld_new = (fld_val == 8'd0) ? fld_lim - 8'd1 : fld_val - 8'd1;
    end
  end

  assign fld_d = div10(fld_new);

  // Event handling
  always_comb begin
    mode_nxt  = mode_r;
    dig_nxt   = dig_r;
    point_nxt = point_r;
    edit_nxt  = edit_r;
    ccnt_nxt  = ccnt_r;
    tcnt_nxt  = tcnt_r;
    vcnt_nxt  = vcnt_r;
    wr        = 1'b0;
    conv      = 1'b0;
    unique case (item.opcode)
      OP_TIME: begin
        if (mode_r == MODE_CLOCK) begin
          point_nxt  = 1'b1;
          dig_nxt[0] = {2'b00, item.hour_bcd[5:4]};
          dig_nxt[1] = item.hour_bcd[3:0];
          dig_nxt[2] = {1'b0, item.minute_bcd[6:4]};
          dig_nxt[3] = item.minute_bcd[3:0];
          ccnt_nxt   = clock_hit ? 6'd0 : ccnt_inc;
          if (clock_hit) begin
            mode_nxt = MODE_TEMP;
          end
        end
      end
      OP_TEMP: begin
        if (mode_r == MODE_TEMP) begin
          point_nxt  = 1'b0;
          dig_nxt[0] = mod10_small(deg_d.quo);
          dig_nxt[1] = deg_d.rem;
          dig_nxt[2] = DIG_C;
          dig_nxt[3] = DIG_BLANK;
          tcnt_nxt   = temp_hit ? 4'd0 : tcnt_inc;
          if (temp_hit) begin
            mode_nxt = MODE_CLOCK;
          end
        end else begin
          vcnt_nxt = conv_hit ? 4'd0 : vcnt_inc;
          conv     = conv_hit;
        end
      end
      OP_KEY: begin
        case (item.key)
          KEY_MODE: begin
            if (mode_r != MODE_SETUP) begin
              // show the time as a clock sample, then enter setup
              point_nxt  = 1'b1;
              dig_nxt[0] = {2'b00, item.hour_bcd[5:4]};
              dig_nxt[1] = item.hour_bcd[3:0];
              dig_nxt[2] = {1'b0, item.minute_bcd[6:4]};
              dig_nxt[3] = item.minute_bcd[3:0];
              ccnt_nxt   = clock_hit ? 6'd0 : ccnt_inc;
              mode_nxt   = MODE_SETUP;
              edit_nxt   = 1'b0;
            end else begin
              edit_nxt = ~edit_r;
            end
          end
          KEY_UP, KEY_DOWN: begin
            if (mode_r == MODE_SETUP) begin
              if (edit_r) begin
                dig_nxt[2] = fld_d.quo[3:0];
                dig_nxt[3] = fld_d.rem;
              end else begin
                dig_nxt[0] = fld_d.quo[3:0];
                dig_nxt[1] = fld_d.rem;
              end
            end
          end
          KEY_OK: begin
            if (mode_r == MODE_SETUP) begin
              wr       = 1'b1;
              mode_nxt = MODE_CLOCK;
              edit_nxt = 1'b0;
            end else begin
              mode_nxt = MODE_TEMP;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result from the updated state
  always_comb begin
    res.digit_hi0        = dig_nxt[0];
    res.digit_hi1        = dig_nxt[1];
    res.digit_lo0        = dig_nxt[2];
    res.digit_lo1        = dig_nxt[3];
    res.point_flash      = point_nxt;
    res.mode             = mode_nxt;
    res.edit_minutes     = (mode_nxt == MODE_SETUP) ? edit_nxt : 1'b0;
    res.time_write       = wr;
    res.write_hour_bcd   = wr ? {dig_r[0][1:0], dig_r[1]} : 6'd0;
    res.write_minute_bcd = wr ? {dig_r[2][2:0], dig_r[3]} : 7'd0;
    res.convert_request  = conv;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CLOCK;
      dig_r   <= '{4'd0, 4'd1, 4'd2, 4'd3};
      point_r <= 1'b0;
      edit_r  <= 1'b0;
      ccnt_r  <= '0;
      tcnt_r  <= '0;
      vcnt_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      dig_r   <= dig_nxt;
      point_r <= point_nxt;
      edit_r  <= edit_nxt;
      ccnt_r  <= ccnt_nxt;
      tcnt_r  <= tcnt_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule

>>> hw/rtl/clock_display_mode_and_time_setter.sv
// Four-digit clock/thermometer display controller. Each transfer on the in_
// channel is one event (time sample, temperature sample or key press) and
// yields exactly one result on the out_ channel: the four digit codes, point,
// mode, setup field, and the time-write and conversion-request pulses. An
// event sits in an input register, is handled by the mode and digit state
// update, and lands in an output register; one event is taken every cycle as
// long as out_ready keeps up. Configuration writes on the cfg_ channel are
// taken at once and belong in idle periods only.
module clock_display_mode_and_time_setter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cdmts_pkg::in_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cdmts_pkg::res_t                out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cdmts_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cdmts_pkg::CfgDataW-1:0] cfg_data
);
  import cdmts_pkg::*;

  cfg_t cfg;
  logic s1_valid_r;
  in_t  s1_data_r;
  logic out_valid_r;
  res_t out_data_r;
  res_t res;
  logic adv;

  cdmts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Held event moves on when the output register is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  cdmts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A time write leaves the display in clock mode
  a_write_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.time_write |-> out_data_r.mode == MODE_CLOCK)
    else $error("time write outside clock mode");

  // Write fields are zero without the write pulse
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.time_write |->
      out_data_r.write_hour_bcd == 6'd0 && out_data_r.write_minute_bcd == 7'd0)
    else $error("write fields set without time write");

  // Field select shows only in setup
  a_edit_setup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.edit_minutes |-> out_data_r.mode == MODE_SETUP)
    else $error("edit select outside setup");

  // A handled event is always presented next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("handled event lost");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cdmts_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] KEY_SPARE = 3'd7;

  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 165;
  localparam int CALM_ITEMS     = 100;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Display controller model plus the queue of frames it expects
  class frame_checker;
    logic [5:0] clock_dwell;
    logic [3:0] temp_dwell;
    logic [3:0] convert_period;
    mode_t      mode;
    logic [3:0] digits[4];
    logic       point;
    logic       edit_sel;
    logic [5:0] clock_cnt;
    logic [3:0] temp_cnt;
    logic [3:0] conv_cnt;
    res_t       expected_frames[$];
    int         errors;
    int         accepted_events;

    function new();
      clock_dwell     = CLOCK_DWELL_RST;
      temp_dwell      = TEMP_DWELL_RST;
      convert_period  = CONVERT_PERIOD_RST;
      mode            = MODE_CLOCK;
      digits[0]       = 4'd0;
      digits[1]       = 4'd1;
      digits[2]       = 4'd2;
      digits[3]       = 4'd3;
      point           = 1'b0;
      edit_sel        = 1'b0;
      clock_cnt       = '0;
      temp_cnt        = '0;
      conv_cnt        = '0;
      errors          = 0;
      accepted_events = 0;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_CLOCK_DWELL:    clock_dwell = val;
        CFG_TEMP_DWELL:     temp_dwell = val[3:0];
        CFG_CONVERT_PERIOD: convert_period = val[3:0];
        default: ;
      endcase
    endfunction

    // Load BCD time into the digits and count toward the temperature handover
    function void show_time(logic [5:0] hour, logic [6:0] minute);
      point     = 1'b1;
      digits[0] = {2'b00, hour[5:4]};
      digits[1] = hour[3:0];
      digits[2] = {1'b0, minute[6:4]};
      digits[3] = minute[3:0];
      clock_cnt = clock_cnt + 6'd1;
      if (clock_cnt >= clock_dwell) begin
        clock_cnt = '0;
        mode      = MODE_TEMP;
      end
    endfunction

    // Up/down on the selected pair; nibbles above 9 go in as they are
    function void step_field(bit up);
      int base;
      int lim;
      int v;
      base = edit_sel ? 2 : 0;
      lim  = edit_sel ? int'(MINUTE_LIMIT) : int'(HOUR_LIMIT);
      v    = int'(digits[base]) * 10 + int'(digits[base+1]);
      if (up) begin
        v = v + 1;
        if (v == lim) v = 0;
      end else begin
        v = v - 1;
        if (v < 0) v = lim - 1;
      end
      digits[base]   = 4'(v / 10);
      digits[base+1] = 4'(v % 10);
    endfunction

    function void note_event(in_t ev);
      res_t       r;
      logic [7:0] t;
      logic       wr;
      logic       conv;
      wr   = 1'b0;
      conv = 1'b0;
      r    = '0;
      accepted_events++;
      case (ev.opcode)
        OP_TIME: begin
          if (mode == MODE_CLOCK) show_time(ev.hour_bcd, ev.minute_bcd);
        end
        OP_TEMP: begin
          if (mode == MODE_TEMP) begin
            // whole degrees from the low byte of the integer part
            t         = ev.temp_raw[11:4];
            point     = 1'b0;
            digits[0] = 4'((t / 8'd10) % 8'd10);
            digits[1] = 4'(t % 8'd10);
            digits[2] = DIG_C;
            digits[3] = DIG_BLANK;
            temp_cnt  = temp_cnt + 4'd1;
            if (temp_cnt >= temp_dwell) begin
              temp_cnt = '0;
              mode     = MODE_CLOCK;
            end
          end else begin
            conv_cnt = conv_cnt + 4'd1;
            if (conv_cnt >= convert_period) begin
              conv     = 1'b1;
              conv_cnt = '0;
            end
          end
        end
        OP_KEY: begin
          case (ev.key)
            KEY_MODE: begin
              if (mode != MODE_SETUP) begin
                mode = MODE_CLOCK;
                show_time(ev.hour_bcd, ev.minute_bcd);
                mode     = MODE_SETUP;
                edit_sel = 1'b0;
              end else begin
                edit_sel = ~edit_sel;
              end
            end
            KEY_UP, KEY_DOWN: begin
              if (mode == MODE_SETUP) step_field(ev.key == KEY_UP);
            end
            KEY_OK: begin
              if (mode == MODE_SETUP) begin
                wr       = 1'b1;
                mode     = MODE_CLOCK;
                edit_sel = 1'b0;
              end else begin
                mode = MODE_TEMP;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.digit_hi0        = digits[0];
      r.digit_hi1        = digits[1];
      r.digit_lo0        = digits[2];
      r.digit_lo1        = digits[3];
      r.point_flash      = point;
      r.mode             = mode;
      r.edit_minutes     = (mode == MODE_SETUP) ? edit_sel : 1'b0;
      r.time_write       = wr;
      r.write_hour_bcd   = wr ? 6'({digits[0], digits[1]}) : 6'd0;
      r.write_minute_bcd = wr ? 7'({digits[2], digits[3]}) : 7'd0;
      r.convert_request  = conv;
      expected_frames.push_back(r);
    endfunction

    function void check_frame(res_t got);
      res_t  want;
      string bad;
      bad = "";
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("result with nothing expected: %h", got);
        return;
      end
      want = expected_frames.pop_front();
      if (got.digit_hi0 !== want.digit_hi0) bad = {bad, " digit_hi0"};
      if (got.digit_hi1 !== want.digit_hi1) bad = {bad, " digit_hi1"};
      if (got.digit_lo0 !== want.digit_lo0) bad = {bad, " digit_lo0"};
      if (got.digit_lo1 !== want.digit_lo1) bad = {bad, " digit_lo1"};
      if (got.point_flash !== want.point_flash) bad = {bad, " point_flash"};
      if (got.mode !== want.mode) bad = {bad, " mode"};
      if (got.edit_minutes !== want.edit_minutes) bad = {bad, " edit_minutes"};
      if (got.time_write !== want.time_write) bad = {bad, " time_write"};
      if (got.write_hour_bcd !== want.write_hour_bcd) bad = {bad, " write_hour_bcd"};
      if (got.write_minute_bcd !== want.write_minute_bcd) bad = {bad, " write_minute_bcd"};
      if (got.convert_request !== want.convert_request) bad = {bad, " convert_request"};
      if (bad != "") begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch in%s: expected %h actual %h", bad, want, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  res_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  frame_checker sb = new();
  int idle_cycles = 0;
  int offered = 0;
  bit calm = 1'b0;
  bit send_gaps = 1'b1;

  clock_display_mode_and_time_setter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_event(in_data);
      if (out_valid && out_ready) sb.check_frame(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result sink: random stalls, one long hold-off so the block backs up
  initial begin : sink
    int  n;
    bit  held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.accepted_events >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic in_t make_event(logic [1:0] op, logic [2:0] k, logic [5:0] h,
                                     logic [6:0] m, logic [15:0] raw);
    in_t ev;
    ev.opcode     = op;
    ev.key        = k;
    ev.hour_bcd   = h;
    ev.minute_bcd = m;
    ev.temp_raw   = raw;
    return ev;
  endfunction

  function automatic in_t random_event(logic [1:0] op, logic [2:0] k);
    return make_event(op, k, 6'($urandom_range(0, 35)), 7'($urandom_range(0, 89)),
                      16'($urandom));
  endfunction

  function automatic in_t any_event();
    int         r;
    logic [1:0] op;
    r = $urandom_range(0, 19);
    if (r < 8) op = OP_TIME;
    else if (r < 15) op = OP_TEMP;
    else if (r < 19) op = OP_KEY;
    else op = OP_UNUSED;
    return random_event(op, 3'($urandom_range(0, 7)));
  endfunction

  // Present one event and hold it until the transfer
  task automatic offer(input in_t ev);
    int gap;
    if (!calm && send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    offered++;
  endtask

  // Drain the block; wait for the clock first so the last transfer is already noted
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [5:0] cd, input logic [3:0] td,
                                input logic [3:0] cp);
    cfg_write(CFG_CLOCK_DWELL, cd);
    cfg_write(CFG_TEMP_DWELL, 6'(td));
    cfg_write(CFG_CONVERT_PERIOD, 6'(cp));
    cfg_valid <= 1'b0;
  endtask

  // Enter setup, edit with random keys, usually confirm with ok
  task automatic setup_session();
    int         steps;
    logic [2:0] k;
    offer(random_event(OP_KEY, KEY_MODE));
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0, 1, 2: k = KEY_UP;
        3, 4, 5: k = KEY_DOWN;
        6, 7:    k = KEY_MODE;
        default: k = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 9) == 0) offer(any_event());
      else offer(random_event(OP_KEY, k));
    end
    if ($urandom_range(0, 4) != 0) offer(random_event(OP_KEY, KEY_OK));
  endtask

  initial begin : stimulus
    int         p;
    int         start;
    int         next_toggle;
    logic [5:0] cd;
    logic [3:0] td;
    logic [3:0] cp;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, clock mode
    offer(make_event(OP_TIME, KEY_NONE, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_TIME, KEY_NONE, 6'h1F, 7'h4F, 16'h0000));
    offer(make_event(OP_UNUSED, KEY_NONE, 6'h3F, 7'h7F, 16'hFFFF));
    // conversion requests outside temperature mode
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h7FFF));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h8000));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'hFFF0));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h0190));
    // ok outside setup jumps to temperature; extremes of the reading
    offer(make_event(OP_KEY, KEY_OK, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h7FFF));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h8000));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'hFFF0));
    offer(make_event(OP_TEMP, KEY_NONE, 6'h00, 7'h00, 16'h0190));
    // setup: wrap up and down on both fields, then write back
    offer(make_event(OP_KEY, KEY_MODE, 6'h23, 7'h59, 16'h0000));
    offer(make_event(OP_KEY, KEY_UP, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_DOWN, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_MODE, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_UP, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_DOWN, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_SPARE, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_OK, 6'h00, 7'h00, 16'h0000));
    // non-decimal nibbles step past the wrap point
    offer(make_event(OP_KEY, KEY_MODE, 6'h1F, 7'h4F, 16'h0000));
    offer(make_event(OP_KEY, KEY_UP, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_MODE, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_DOWN, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_OK, 6'h00, 7'h00, 16'h0000));
    offer(make_event(OP_KEY, KEY_UP, 6'h00, 7'h00, 16'h0000));

    // Random phases, each under its own register settings
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin cd = 6'd1;  td = 4'd1;  cp = 4'd1;  end
        1: begin cd = 6'd63; td = 4'd15; cp = 4'd15; end
        2: begin cd = 6'd0;  td = 4'd0;  cp = 4'd0;  end
        default: begin
          cd = 6'($urandom_range(1, 63));
          td = 4'($urandom_range(1, 15));
          cp = 4'($urandom_range(1, 15));
        end
      endcase
      apply_settings(cd, td, cp);
      start       = offered;
      next_toggle = offered;
      while (offered - start < PHASE_ITEMS) begin
        calm = (p == PHASES - 1) && (offered - start >= PHASE_ITEMS - CALM_ITEMS);
        if (offered >= next_toggle) begin
          send_gaps   = ($urandom_range(0, 2) != 0);
          next_toggle = offered + 40;
        end
        if ($urandom_range(0, 7) == 0) setup_session();
        else offer(any_event());
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
